### hdl/tds_pkg.sv
// tds_pkg: shared types and constants of the transient detector
// no dependencies; used by tds_sqrt and transient_detector_sigma_rate
package tds_pkg;

   localparam int SAMPLE_BITS = 32;
   localparam int STAMP_BITS  = 48;
   localparam int VAR_BITS    = 64;
   localparam int ROOT_BITS   = VAR_BITS / 2;
   localparam int GAIN_BITS   = 16;
   localparam int LEVEL_BITS  = 31;
   localparam int RUN_BITS    = 8;
   localparam int LHS_BITS    = 42;

   localparam logic [VAR_BITS-1:0] VAR_FLOOR = 64'd429497;
   localparam logic [5:0]          EMA_DIV   = 6'd50;

   typedef enum logic [2:0] {
      REG_DETECT_MODE = 3'd0,
      REG_MIN_LEVEL   = 3'd1,
      REG_SIGMA_GAIN  = 3'd2,
      REG_RUN_NEEDED  = 3'd3,
      REG_SLOPE_LIMIT = 3'd4
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_SQUARE,
      ST_SEED,
      ST_SQRT,
      ST_SCALE,
      ST_DECIDE,
      ST_EMA_DIV,
      ST_EMA_SUB,
      ST_EMA_ADD,
      ST_RATE_PREP,
      ST_RATE_MUL,
      ST_RATE_END,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic start;
      logic done;
   } sqrt_ctl_type;

endpackage

### hdl/tds_sqrt.sv
// tds_sqrt: iterative integer square root, two radicand bits per cycle
// depends on tds_pkg
module tds_sqrt (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [tds_pkg::VAR_BITS-1:0]    radicand,
   output tds_pkg::sqrt_ctl_type           ctl,
   output logic [tds_pkg::ROOT_BITS-1:0]   root
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [4:0]                    cnt_ff, cnt_in;
   logic [tds_pkg::VAR_BITS-1:0]  rad_ff, rad_in;
   logic [tds_pkg::ROOT_BITS+1:0] rem_ff, rem_in;
   logic [tds_pkg::ROOT_BITS-1:0] root_ff, root_in;
   logic [tds_pkg::ROOT_BITS+2:0] trial_rem;
   logic [tds_pkg::ROOT_BITS+2:0] trial;

   always_comb begin
      trial_rem = {rem_ff[tds_pkg::ROOT_BITS:0], rad_ff[tds_pkg::VAR_BITS-1 -: 2]};
      trial     = {1'b0, root_ff, 2'b01};
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      rad_in    = rad_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in = {rad_ff[tds_pkg::VAR_BITS-3:0], 2'b00};
         if (trial_rem >= trial) begin
            rem_in  = tds_pkg::ROOT_BITS'(trial_rem - trial) == '0 ?
                      '0 : (tds_pkg::ROOT_BITS+2)'(trial_rem - trial);
            root_in = {root_ff[tds_pkg::ROOT_BITS-2:0], 1'b1};
         end else begin
            rem_in  = (tds_pkg::ROOT_BITS+2)'(trial_rem);
            root_in = {root_ff[tds_pkg::ROOT_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(tds_pkg::ROOT_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign ctl.start = start;
   assign ctl.done  = done_ff;
   assign root      = root_ff;

endmodule

### hdl/transient_detector_sigma_rate.sv
// transient_detector_sigma_rate: adaptive k-sigma / rate-of-change detector
// depends on tds_pkg and tds_sqrt
//
// usage: a request on req_* carries one current sample, its baseline, its
// timestamp and a clear flag (req_tuser); each yields one response on rsp_*:
// the fired flag and the adaptive threshold used (zero in rate mode).
// req_tready is high while no request is in work. adaptive mode: setup, the
// bit-serial dev^2 multiplier, seed, the square root unit (start, 32 two-bit
// steps, done), the serial gain multiplier, decide and output; quiet samples
// also pass the pair of divide-by-50 units and the update before output.
// rate mode: setup, the serial slope multiplier, compare and output; a
// priming sample goes from setup straight to output. no new request is taken
// until the last one has reached the output register, which holds the
// response; a new request is accepted while it waits, and a finished result
// is held until that register is free, so a stalled receiver holds up the
// block without loss. reset (synchronous, active high) loads the register
// reset values and clears all detector state. a csr write to a valid index
// stores the value and clears all detector state; csr writes are for the
// user to make only while idle, the block itself does not enforce this.
module transient_detector_sigma_rate (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [31:0] sample, [63:32] baseline, [111:64] stamp_us
   input  logic [111:0] req_tdata,
   // [0] clear_run
   input  logic [0:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [0] fired, [32:1] threshold_now, [39:33] zero
   output logic [39:0]  rsp_tdata,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [30:0]  csr_wdata
);

   localparam int SB = tds_pkg::SAMPLE_BITS;
   localparam int TB = tds_pkg::STAMP_BITS;
   localparam int VB = tds_pkg::VAR_BITS;
   localparam int RB = tds_pkg::ROOT_BITS;
   localparam int GB = tds_pkg::GAIN_BITS;
   localparam int LB = tds_pkg::LEVEL_BITS;
   localparam int HB = tds_pkg::LHS_BITS;

   tds_pkg::state_type state_ff, state_in;

   // configuration
   logic          mode_ff;
   logic [LB-1:0] min_level_ff;
   logic [GB-1:0] gain_ff;
   logic [7:0]    run_needed_ff;
   logic [LB-1:0] slope_ff;

   // detector state
   logic [7:0]    run_ff, run_in;
   logic [VB-1:0] var_ff, var_in;
   logic          seeded_ff, seeded_in;
   logic [SB-1:0] prev_sample_ff, prev_sample_in;
   logic [TB-1:0] prev_stamp_ff, prev_stamp_in;
   logic          primed_ff, primed_in;

   // request capture and work registers
   logic [SB-1:0]  sample_ff, sample_in;
   logic [SB-1:0]  base_ff, base_in;
   logic [TB-1:0]  stamp_ff, stamp_in;
   logic [SB-1:0]  mag_ff, mag_in;
   logic [SB-1:0]  mq_ff, mq_in;
   logic [VB-1:0]  acc_ff, acc_in;
   logic [VB-1:0]  dev2_ff, dev2_in;
   logic [RB-1:0]  sigma_ff, sigma_in;
   logic [GB-1:0]  gq_ff, gq_in;
   logic [47:0]    prod_ff, prod_in;
   logic [VB-1:0]  dq_v_ff, dq_v_in;
   logic [VB-1:0]  dq_d_ff, dq_d_in;
   logic [5:0]     rem_v_ff, rem_v_in;
   logic [5:0]     rem_d_ff, rem_d_in;
   logic [6:0]     step_ff, step_in;
   logic [TB-1:0]  dt_ff, dt_in;
   logic           dt_ok_ff, dt_ok_in;
   logic [HB-1:0]  lhs_ff, lhs_in;
   logic [LB-1:0]  lq_ff, lq_in;
   logic [TB:0]    racc_ff, racc_in;
   logic           ovf_ff, ovf_in;
   logic           fired_ff, fired_in;
   logic [31:0]    thr_ff, thr_in;

   logic           rsp_valid_ff, rsp_valid_in;
   logic [39:0]    rsp_data_ff, rsp_data_in;

   tds_pkg::sqrt_ctl_type sqrt_ctl;
   logic                  sqrt_start;
   logic [RB-1:0]         sqrt_root;

   // combinational helpers
   logic [SB:0]   diff;
   logic [SB:0]   diff_abs;
   logic [SB:0]   sq_sum;
   logic [SB:0]   sc_sum;
   logic [35:0]   scaled;
   logic [35:0]   thr_full;
   logic [7:0]    need;
   logic [6:0]    tv, td;
   logic [VB:0]   wide_sum;
   logic [HB+1:0] lhs_calc;
   logic [TB:0]   racc_next;
   logic          cfg_hit;
   logic          accept;

   tds_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (var_ff),
      .ctl      (sqrt_ctl),
      .root     (sqrt_root)
   );

   assign accept  = req_tvalid && req_tready;
   assign cfg_hit = csr_we && (csr_index <= 3'(tds_pkg::REG_SLOPE_LIMIT));

   always_comb begin
      state_in       = state_ff;
      run_in         = run_ff;
      var_in         = var_ff;
      seeded_in      = seeded_ff;
      prev_sample_in = prev_sample_ff;
      prev_stamp_in  = prev_stamp_ff;
      primed_in      = primed_ff;
      sample_in      = sample_ff;
      base_in        = base_ff;
      stamp_in       = stamp_ff;
      mag_in         = mag_ff;
      mq_in          = mq_ff;
      acc_in         = acc_ff;
      dev2_in        = dev2_ff;
      sigma_in       = sigma_ff;
      gq_in          = gq_ff;
      prod_in        = prod_ff;
      dq_v_in        = dq_v_ff;
      dq_d_in        = dq_d_ff;
      rem_v_in       = rem_v_ff;
      rem_d_in       = rem_d_ff;
      step_in        = step_ff;
      dt_in          = dt_ff;
      dt_ok_in       = dt_ok_ff;
      lhs_in         = lhs_ff;
      lq_in          = lq_ff;
      racc_in        = racc_ff;
      ovf_in         = ovf_ff;
      fired_in       = fired_ff;
      thr_in         = thr_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      sqrt_start     = 1'b0;
      req_tready     = (state_ff == tds_pkg::ST_IDLE);

      // shared difference: sample minus baseline or previous sample
      if (state_ff == tds_pkg::ST_RATE_PREP) begin
         diff = {sample_ff[SB-1], sample_ff} - {prev_sample_ff[SB-1], prev_sample_ff};
      end else begin
         diff = {sample_ff[SB-1], sample_ff} - {base_ff[SB-1], base_ff};
      end
      diff_abs  = diff[SB] ? (~diff + (SB+1)'(1)) : diff;
      sq_sum    = {1'b0, acc_ff[VB-1:SB]} + (mq_ff[0] ? {1'b0, mag_ff} : '0);
      sc_sum    = {1'b0, prod_ff[47:GB]} + (gq_ff[0] ? {1'b0, sigma_ff} : '0);
      scaled    = prod_ff[47:12];
      thr_full  = (scaled > {5'd0, min_level_ff}) ? scaled : {5'd0, min_level_ff};
      need      = (run_needed_ff == 8'd0) ? 8'd1 : run_needed_ff;
      tv        = {rem_v_ff, dq_v_ff[VB-1]};
      td        = {rem_d_ff, dq_d_ff[VB-1]};
      wide_sum  = '0;
      lhs_calc  = ({diff_abs[SB-1:0], 10'd0} - {4'd0, diff_abs[SB-1:0], 4'd0})
                  - {5'd0, diff_abs[SB-1:0], 3'd0};
      racc_next = {racc_ff[HB-1:0], 1'b0} + (lq_ff[LB-1] ? {1'b0, dt_ff} : '0);

      unique case (state_ff)
         tds_pkg::ST_IDLE: begin
            if (accept) begin
               sample_in = req_tdata[SB-1:0];
               base_in   = req_tdata[2*SB-1:SB];
               stamp_in  = req_tdata[2*SB+TB-1:2*SB];
               if (req_tuser[0]) begin
                  run_in    = '0;
                  primed_in = 1'b0;
               end
               state_in = mode_ff ? tds_pkg::ST_RATE_PREP : tds_pkg::ST_PREP;
            end
         end
         tds_pkg::ST_PREP: begin
            mag_in   = diff_abs[SB-1:0];
            mq_in    = diff_abs[SB-1:0];
            acc_in   = '0;
            step_in  = '0;
            state_in = tds_pkg::ST_SQUARE;
         end
         tds_pkg::ST_SQUARE: begin
            // shift-add, one multiplier bit per cycle
            acc_in  = {sq_sum, acc_ff[SB-1:1]};
            mq_in   = {1'b0, mq_ff[SB-1:1]};
            step_in = step_ff + 7'd1;
            if (step_ff == 7'(SB - 1)) begin
               state_in = tds_pkg::ST_SEED;
            end
         end
         tds_pkg::ST_SEED: begin
            dev2_in = acc_ff;
            if (!seeded_ff) begin
               wide_sum  = {1'b0, acc_ff} + {1'b0, tds_pkg::VAR_FLOOR};
               var_in    = wide_sum[VB] ? '1 : wide_sum[VB-1:0];
               seeded_in = 1'b1;
            end
            state_in = tds_pkg::ST_SQRT;
         end
         tds_pkg::ST_SQRT: begin
            // start pulse on entry, then wait for the root
            sqrt_start = (step_ff != 7'd0);
            step_in    = '0;
            if (sqrt_ctl.done && !sqrt_ctl.start) begin
               sigma_in = sqrt_root;
               gq_in    = gain_ff;
               prod_in  = '0;
               state_in = tds_pkg::ST_SCALE;
            end
         end
         tds_pkg::ST_SCALE: begin
            prod_in = {sc_sum, prod_ff[GB-1:1]};
            gq_in   = {1'b0, gq_ff[GB-1:1]};
            step_in = step_ff + 7'd1;
            if (step_ff == 7'(GB - 1)) begin
               state_in = tds_pkg::ST_DECIDE;
            end
         end
         tds_pkg::ST_DECIDE: begin
            thr_in = (thr_full[35:32] != 4'd0) ? '1 : thr_full[31:0];
            if ({4'd0, mag_ff} > thr_full) begin
               if ((run_ff + 8'd1) >= need) begin
                  run_in   = '0;
                  fired_in = 1'b1;
               end else begin
                  run_in   = run_ff + 8'd1;
                  fired_in = 1'b0;
               end
               state_in = tds_pkg::ST_OUT;
            end else begin
               run_in   = '0;
               fired_in = 1'b0;
               dq_v_in  = var_ff;
               dq_d_in  = dev2_ff;
               rem_v_in = '0;
               rem_d_in = '0;
               step_in  = '0;
               state_in = tds_pkg::ST_EMA_DIV;
            end
         end
         tds_pkg::ST_EMA_DIV: begin
            // restoring divide by 50, one quotient bit per cycle
            if (tv >= {1'b0, tds_pkg::EMA_DIV}) begin
               rem_v_in = 6'(tv - {1'b0, tds_pkg::EMA_DIV});
               dq_v_in  = {dq_v_ff[VB-2:0], 1'b1};
            end else begin
               rem_v_in = tv[5:0];
               dq_v_in  = {dq_v_ff[VB-2:0], 1'b0};
            end
            if (td >= {1'b0, tds_pkg::EMA_DIV}) begin
               rem_d_in = 6'(td - {1'b0, tds_pkg::EMA_DIV});
               dq_d_in  = {dq_d_ff[VB-2:0], 1'b1};
            end else begin
               rem_d_in = td[5:0];
               dq_d_in  = {dq_d_ff[VB-2:0], 1'b0};
            end
            step_in = step_ff + 7'd1;
            if (step_ff == 7'(VB - 1)) begin
               state_in = tds_pkg::ST_EMA_SUB;
            end
         end
         tds_pkg::ST_EMA_SUB: begin
            dq_v_in  = var_ff - dq_v_ff;
            state_in = tds_pkg::ST_EMA_ADD;
         end
         tds_pkg::ST_EMA_ADD: begin
            wide_sum = {1'b0, dq_v_ff} + {1'b0, dq_d_ff};
            var_in   = wide_sum[VB] ? '1 : wide_sum[VB-1:0];
            state_in = tds_pkg::ST_OUT;
         end
         tds_pkg::ST_RATE_PREP: begin
            thr_in         = '0;
            fired_in       = 1'b0;
            prev_sample_in = sample_ff;
            prev_stamp_in  = stamp_ff;
            if (!primed_ff) begin
               primed_in = 1'b1;
               state_in  = tds_pkg::ST_OUT;
            end else begin
               dt_ok_in = (stamp_ff > prev_stamp_ff);
               dt_in    = stamp_ff - prev_stamp_ff;
               lhs_in   = lhs_calc[HB-1:0];
               lq_in    = slope_ff;
               racc_in  = '0;
               ovf_in   = 1'b0;
               step_in  = '0;
               state_in = tds_pkg::ST_RATE_MUL;
            end
         end
         tds_pkg::ST_RATE_MUL: begin
            // dt * slope_limit, msb first, sticky once past the lhs range
            racc_in = racc_next;
            if (racc_next[TB:HB] != '0) begin
               ovf_in = 1'b1;
            end
            lq_in   = {lq_ff[LB-2:0], 1'b0};
            step_in = step_ff + 7'd1;
            if (step_ff == 7'(LB - 1)) begin
               state_in = tds_pkg::ST_RATE_END;
            end
         end
         tds_pkg::ST_RATE_END: begin
            fired_in = dt_ok_ff && (lhs_ff != '0) && !ovf_ff && (racc_ff[HB-1:0] < lhs_ff);
            state_in = tds_pkg::ST_OUT;
         end
         tds_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {7'd0, thr_ff, fired_ff};
               state_in     = tds_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tds_pkg::ST_IDLE;
         end
      endcase

      if (state_ff == tds_pkg::ST_SEED) begin
         step_in = 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= tds_pkg::ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         mode_ff        <= 1'b0;
         min_level_ff   <= '0;
         gain_ff        <= 16'd16384;
         run_needed_ff  <= 8'd1;
         slope_ff       <= '0;
         run_ff         <= '0;
         var_ff         <= tds_pkg::VAR_FLOOR;
         seeded_ff      <= 1'b0;
         prev_sample_ff <= '0;
         prev_stamp_ff  <= '0;
         primed_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cfg_hit) begin
            unique case (tds_pkg::reg_index_type'(csr_index))
               tds_pkg::REG_DETECT_MODE: mode_ff       <= csr_wdata[0];
               tds_pkg::REG_MIN_LEVEL:   min_level_ff  <= csr_wdata;
               tds_pkg::REG_SIGMA_GAIN:  gain_ff       <= csr_wdata[GB-1:0];
               tds_pkg::REG_RUN_NEEDED:  run_needed_ff <= csr_wdata[7:0];
               tds_pkg::REG_SLOPE_LIMIT: slope_ff      <= csr_wdata;
               default:                  mode_ff       <= mode_ff;
            endcase
            run_ff         <= '0;
            var_ff         <= tds_pkg::VAR_FLOOR;
            seeded_ff      <= 1'b0;
            prev_sample_ff <= '0;
            prev_stamp_ff  <= '0;
            primed_ff      <= 1'b0;
         end else begin
            run_ff         <= run_in;
            var_ff         <= var_in;
            seeded_ff      <= seeded_in;
            prev_sample_ff <= prev_sample_in;
            prev_stamp_ff  <= prev_stamp_in;
            primed_ff      <= primed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      base_ff     <= base_in;
      stamp_ff    <= stamp_in;
      mag_ff      <= mag_in;
      mq_ff       <= mq_in;
      acc_ff      <= acc_in;
      dev2_ff     <= dev2_in;
      sigma_ff    <= sigma_in;
      gq_ff       <= gq_in;
      prod_ff     <= prod_in;
      dq_v_ff     <= dq_v_in;
      dq_d_ff     <= dq_d_in;
      rem_v_ff    <= rem_v_in;
      rem_d_ff    <= rem_d_in;
      step_ff     <= step_in;
      dt_ff       <= dt_in;
      dt_ok_ff    <= dt_ok_in;
      lhs_ff      <= lhs_in;
      lq_ff       <= lq_in;
      racc_ff     <= racc_in;
      ovf_ff      <= ovf_in;
      fired_ff    <= fired_in;
      thr_ff      <= thr_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
